// ===== hw/rtl/bbf_pkg.sv =====
// Shared types and constants of the blocked Bloom filter.
package bbf_pkg;

    localparam int SLOT_BITS     = 512;
    localparam int WORD_BITS     = 64;
    localparam int WORDS_PER_SLOT = SLOT_BITS / WORD_BITS;
    localparam int WSEL_W        = $clog2(WORDS_PER_SLOT);
    localparam int BIT_W         = $clog2(SLOT_BITS);
    localparam int OFS_W         = $clog2(WORD_BITS);
    localparam int HASH_W        = 64;
    localparam int NUM_W         = HASH_W - BIT_W;
    localparam int DIV_W         = 17;
    localparam int DCNT_W        = 6;
    localparam int CNT_W         = 5;
    localparam int TOTAL_W       = 11;
    localparam int CMD_W         = 2;

    localparam logic [CNT_W-1:0]   SWAP_PROBE    = 5'd8;
    localparam logic [CNT_W-1:0]   REFILL_PROBE  = 5'd15;
    localparam logic [CNT_W-1:0]   MIN_LIMIT     = 5'd2;
    localparam logic [CNT_W-1:0]   LIMIT_RESET   = 5'd8;
    localparam logic [TOTAL_W-1:0] TOTAL_RESET   = 11'd1024;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic REG_SLOT_TOTAL  = 1'b0;
    localparam logic REG_PROBE_LIMIT = 1'b1;

    typedef struct packed {
        logic load;
        logic div_step;
        logic probe_rd;
        logic probe_wr;
        logic next_probe;
        logic clr_start;
        logic clr_step;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic probe_last;
        logic bit_set;
        logic clr_last;
    } t_sts;

endpackage

// ===== hw/rtl/bbf_dpath.sv =====
// Datapath: hash registers, slot remainder unit, probe sequencing and the bit store.
module bbf_dpath #(
    parameter int NUM_SLOTS = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bbf_pkg::t_cmd               i_cmd,
    output bbf_pkg::t_sts               o_sts,
    input  logic [bbf_pkg::HASH_W-1:0]  i_fh_lo,
    input  logic [bbf_pkg::HASH_W-1:0]  i_fh_hi,
    input  logic [bbf_pkg::HASH_W-1:0]  i_sh_lo,
    input  logic [bbf_pkg::HASH_W-1:0]  i_sh_hi,
    input  logic [bbf_pkg::TOTAL_W-1:0] i_slot_total,
    input  logic [bbf_pkg::CNT_W-1:0]   i_probe_limit
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int DEPTH  = NUM_SLOTS * bbf_pkg::WORDS_PER_SLOT;
    localparam int ADDR_W = SLOT_W + bbf_pkg::WSEL_W;

    logic [bbf_pkg::HASH_W-1:0]  r_lo, r_hi, r_slo, r_shi;
    logic [bbf_pkg::NUM_W-1:0]   r_num;
    logic [bbf_pkg::DIV_W-1:0]   r_rem;
    logic [bbf_pkg::DCNT_W-1:0]  r_div_cnt;
    logic [bbf_pkg::BIT_W-1:0]   r_bit;
    logic [bbf_pkg::CNT_W-1:0]   r_count;
    logic [ADDR_W-1:0]           r_clr_addr;
    logic [bbf_pkg::WORD_BITS-1:0] r_rdata;
    logic [bbf_pkg::WORD_BITS-1:0] r_mem [DEPTH];

    logic [bbf_pkg::DIV_W-1:0]   w_used;
    logic [bbf_pkg::DIV_W-1:0]   w_trial;
    logic [bbf_pkg::DIV_W-1:0]   n_rem;
    logic [bbf_pkg::CNT_W-1:0]   w_lim;
    logic [bbf_pkg::CNT_W-1:0]   w_cnt_n;
    logic [ADDR_W-1:0]           w_addr;

    always_comb begin
        if (i_slot_total == '0) begin
            w_used = bbf_pkg::DIV_W'(1);
        end else if (bbf_pkg::DIV_W'(i_slot_total) > bbf_pkg::DIV_W'(NUM_SLOTS)) begin
            w_used = bbf_pkg::DIV_W'(NUM_SLOTS);
        end else begin
            w_used = bbf_pkg::DIV_W'(i_slot_total);
        end
        w_trial = {r_rem[bbf_pkg::DIV_W-2:0], r_num[bbf_pkg::NUM_W-1]};
        n_rem   = (w_trial >= w_used) ? (w_trial - w_used) : w_trial;
        w_lim   = (i_probe_limit < bbf_pkg::MIN_LIMIT) ? bbf_pkg::MIN_LIMIT : i_probe_limit;
        w_cnt_n = r_count + 1'b1;
        w_addr  = {r_rem[SLOT_W-1:0], r_bit[bbf_pkg::BIT_W-1:bbf_pkg::OFS_W]};
    end

    assign o_sts.div_done   = (r_div_cnt == bbf_pkg::DCNT_W'(bbf_pkg::NUM_W));
    assign o_sts.probe_last = (w_cnt_n == w_lim);
    assign o_sts.bit_set    = r_rdata[r_bit[bbf_pkg::OFS_W-1:0]];
    assign o_sts.clr_last   = (r_clr_addr == ADDR_W'(DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lo      <= i_fh_lo;
            r_hi      <= i_fh_hi;
            r_slo     <= i_sh_lo;
            r_shi     <= i_sh_hi;
            r_num     <= i_fh_lo[bbf_pkg::HASH_W-1:bbf_pkg::BIT_W];
            r_rem     <= '0;
            r_div_cnt <= '0;
            r_bit     <= i_fh_lo[bbf_pkg::BIT_W-1:0];
            r_count   <= bbf_pkg::CNT_W'(1);
        end else if (i_cmd.div_step) begin
            r_num     <= {r_num[bbf_pkg::NUM_W-2:0], 1'b0};
            r_rem     <= n_rem;
            r_div_cnt <= r_div_cnt + 1'b1;
        end else if (i_cmd.next_probe) begin
            r_count <= w_cnt_n;
            r_bit   <= r_hi[bbf_pkg::BIT_W-1:0];
            if (w_cnt_n == bbf_pkg::SWAP_PROBE) begin
                r_lo <= r_slo;
                r_hi <= r_shi;
            end else if (w_cnt_n == bbf_pkg::REFILL_PROBE) begin
                r_hi <= r_lo;
            end else begin
                r_hi <= r_hi >> bbf_pkg::BIT_W;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_start) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_cmd.probe_wr) begin
            r_mem[w_addr] <= r_rdata | (bbf_pkg::WORD_BITS'(1) << r_bit[bbf_pkg::OFS_W-1:0]);
        end
        if (i_cmd.probe_rd) begin
            r_rdata <= r_mem[w_addr];
        end
    end

endmodule

// ===== hw/rtl/bbf_ctrl.sv =====
// Controller state machine that sequences accept, remainder, probes, clearing and result.
module bbf_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [bbf_pkg::CMD_W-1:0] i_command,
    output logic                      o_ready,
    input  logic                      i_out_busy,
    output logic                      o_done,
    output logic                      o_found,
    output bbf_pkg::t_cmd             o_cmd,
    input  bbf_pkg::t_sts             i_sts
);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_CHK  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]                r_state, n_state;
    logic [bbf_pkg::CMD_W-1:0] r_command, n_command;
    logic                      r_found, n_found;

    always_comb begin
        n_state   = r_state;
        n_command = r_command;
        n_found   = r_found;
        o_cmd     = '0;
        o_ready   = 1'b0;
        o_done    = 1'b0;
        case (r_state)
            ST_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_found = 1'b1;
                    n_state = (r_command == bbf_pkg::CMD_CLEAR) ? ST_FIN : ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_command = i_command;
                    case (i_command)
                        bbf_pkg::CMD_ADD, bbf_pkg::CMD_QUERY: begin
                            o_cmd.load = 1'b1;
                            n_state    = ST_DIV;
                        end
                        bbf_pkg::CMD_CLEAR: begin
                            o_cmd.clr_start = 1'b1;
                            n_state         = ST_CLR;
                        end
                        default: begin
                            n_found = 1'b0;
                            n_state = ST_FIN;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.probe_rd = 1'b1;
                    n_state        = ST_CHK;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            ST_RD: begin
                o_cmd.probe_rd = 1'b1;
                n_state        = ST_CHK;
            end
            ST_CHK: begin
                if (r_command == bbf_pkg::CMD_ADD) begin
                    o_cmd.probe_wr = 1'b1;
                end
                if (r_command == bbf_pkg::CMD_QUERY && !i_sts.bit_set) begin
                    n_found = 1'b0;
                    n_state = ST_FIN;
                end else if (i_sts.probe_last) begin
                    n_found = 1'b1;
                    n_state = ST_FIN;
                end else begin
                    o_cmd.next_probe = 1'b1;
                    n_state          = ST_RD;
                end
            end
            ST_FIN: begin
                if (!i_out_busy) begin
                    o_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_found = r_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLR;
            r_command <= bbf_pkg::CMD_ADD;
            r_found   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_command <= n_command;
            r_found   <= n_found;
        end
    end

    a_done_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !i_out_busy) else $error("Result issued while output is occupied.");

    a_chk_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHK) |-> ($past(r_state) == ST_RD || $past(r_state) == ST_DIV))
        else $error("Probe check without a preceding read.");

    a_clear_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLR && n_state != ST_CLR) |-> i_sts.clr_last)
        else $error("Clearing pass left early.");

    a_write_only_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.probe_wr |-> (r_command == bbf_pkg::CMD_ADD))
        else $error("Store written by a non-add transfer.");

endmodule

// ===== hw/rtl/blocked_bloom_filter.sv =====
// Top level of the blocked Bloom filter: stream ports, register port and result register.
// An add or query transfer is accepted, then the slot remainder is formed (one quotient
// bit per cycle in the restoring remainder unit), then each probed bit gets a registered
// read of the bit store followed by the check and, for add, the write back; the result
// is handed over once the output register can take it, and a query ends at its first
// clear bit. A clear transfer sweeps the store one word per cycle, and the same sweep
// runs after reset before the first transfer is taken.
module blocked_bloom_filter #(
    parameter int NUM_SLOTS = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [255:0]  s_tdata,  // first_hash_low, first_hash_high, second_hash_low,
                                    // second_hash_high
    input  logic [1:0]    s_tuser,  // command
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,  // found, zero filled
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic [bbf_pkg::TOTAL_W-1:0] r_slot_total;
    logic [bbf_pkg::CNT_W-1:0]   r_probe_limit;
    logic                        r_out_valid;
    logic                        r_out_found;
    logic                        w_done;
    logic                        w_found;
    logic                        w_out_busy;
    bbf_pkg::t_cmd               w_cmd;
    bbf_pkg::t_sts               w_sts;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == bbf_pkg::REG_PROBE_LIMIT) ? 32'(r_probe_limit)
                                                           : 32'(r_slot_total);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_total  <= bbf_pkg::TOTAL_RESET;
            r_probe_limit <= bbf_pkg::LIMIT_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == bbf_pkg::REG_SLOT_TOTAL) begin
                r_slot_total <= pwdata[bbf_pkg::TOTAL_W-1:0];
            end else begin
                r_probe_limit <= pwdata[bbf_pkg::CNT_W-1:0];
            end
        end
    end

    assign w_out_busy = r_out_valid && !m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_found <= w_found;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {7'b0, r_out_found};

    bbf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_tvalid),
        .i_command  (s_tuser),
        .o_ready    (s_tready),
        .i_out_busy (w_out_busy),
        .o_done     (w_done),
        .o_found    (w_found),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    bbf_dpath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_fh_lo       (s_tdata[63:0]),
        .i_fh_hi       (s_tdata[127:64]),
        .i_sh_lo       (s_tdata[191:128]),
        .i_sh_hi       (s_tdata[255:192]),
        .i_slot_total  (r_slot_total),
        .i_probe_limit (r_probe_limit)
    );

endmodule
